FILE: hw/rtl/rwh_pkg.sv
// Shared types, constants and the arctangent table of the window hue block.
`default_nettype none
package rwh_pkg;

  localparam int SUM_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

  // Datapath widths of the vectoring rotator: x and y in Q16, angle in degrees Q16.
  localparam int CW = 41;
  localparam int ZW = 26;
  localparam int HUE_W = 9;

  localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;
  localparam logic signed [ZW-1:0] ANGLE_90 = 26'sd5898240;
  localparam logic signed [ZW-1:0] ANGLE_180 = 26'sd11796480;
  localparam logic [ZW-17:0] HUE_LIMIT = 10'd180;

  localparam int QDEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 8'd3;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CLASSIFY,
    ST_ROTATE,
    ST_FINISH
  } back_state_t;

  // atan(2^-i) in degrees, Q16.
  function automatic logic [21:0] atan_deg(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rwh_front.sv
// Pixel intake: window registers, window test and saturating accumulators.
`default_nettype none
module rwh_front #(
  parameter int COMPONENT_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [9:0]                       pixel_x,
  input  wire logic [9:0]                       pixel_y,
  input  wire logic [7:0]                       red_value,
  input  wire logic [7:0]                       green_value,
  input  wire logic [7:0]                       blue_value,
  input  wire logic                             frame_last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rwh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [9:0]                       cfg_data,
  input  wire rwh_pkg::q_status_t               q_status,
  output logic                                  push,
  output rwh_pkg::sums_t                        push_data
);

  localparam logic [7:0] CMASK = 8'((1 << COMPONENT_BITS) - 1);

  logic [9:0] window_left, window_top;
  logic [6:0] window_width, window_height;
  logic [rwh_pkg::SUM_W-1:0] red_acc, green_acc, blue_acc;
  logic [rwh_pkg::SUM_W-1:0] red_next, green_next, blue_next;
  logic [10:0] col_end, row_end;
  logic in_window, accept;

  assign cfg_ready = 1'b1;
  assign in_ready = !q_status.full;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left <= 10'd310;
      window_top <= 10'd230;
      window_width <= 7'd20;
      window_height <= 7'd20;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rwh_pkg::REG_WINDOW_LEFT:   window_left <= cfg_data;
        rwh_pkg::REG_WINDOW_TOP:    window_top <= cfg_data;
        rwh_pkg::REG_WINDOW_WIDTH:  window_width <= cfg_data[6:0];
        rwh_pkg::REG_WINDOW_HEIGHT: window_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  function automatic logic [rwh_pkg::SUM_W-1:0] sat_add(
    input logic [rwh_pkg::SUM_W-1:0] acc,
    input logic [7:0] v
  );
    logic [rwh_pkg::SUM_W:0] s;
    s = {1'b0, acc} + {{(rwh_pkg::SUM_W - 7){1'b0}}, v};
    return s[rwh_pkg::SUM_W] ? rwh_pkg::SUM_MAX : s[rwh_pkg::SUM_W-1:0];
  endfunction

  always_comb begin
    col_end = {1'b0, window_left} + {4'b0, window_width};
    row_end = {1'b0, window_top} + {4'b0, window_height};
    in_window = ({1'b0, pixel_x} >= {1'b0, window_left}) && ({1'b0, pixel_x} < col_end) &&
                ({1'b0, pixel_y} >= {1'b0, window_top}) && ({1'b0, pixel_y} < row_end);
    red_next = red_acc;
    green_next = green_acc;
    blue_next = blue_acc;
    if (in_window) begin
      red_next = sat_add(red_acc, red_value & CMASK);
      green_next = sat_add(green_acc, green_value & CMASK);
      blue_next = sat_add(blue_acc, blue_value & CMASK);
    end
  end

  assign push = accept && frame_last;
  assign push_data = '{red: red_next, green: green_next, blue: blue_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      red_acc <= '0;
      green_acc <= '0;
      blue_acc <= '0;
    end else if (accept) begin
      if (frame_last) begin
        red_acc <= '0;
        green_acc <= '0;
        blue_acc <= '0;
      end else begin
        red_acc <= red_next;
        green_acc <= green_next;
        blue_acc <= blue_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rwh_queue.sv
// Two-entry queue of frame sums between the pixel intake and the hue engine.
`default_nettype none
module rwh_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire rwh_pkg::sums_t     push_data,
  input  wire logic               pop,
  output rwh_pkg::sums_t          head,
  output rwh_pkg::q_status_t      status
);

  localparam int PW = $clog2(rwh_pkg::QDEPTH);

  rwh_pkg::sums_t entry [rwh_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] count;

  assign head = entry[rd_ptr];
  assign status.full = (count == (PW + 1)'(rwh_pkg::QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rwh_back.sv
// Hue engine: gray test, iterative vectoring rotator and the result register.
`default_nettype none
module rwh_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire rwh_pkg::sums_t                        head,
  input  wire rwh_pkg::q_status_t                    q_status,
  output logic                                       pop,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       is_gray,
  output logic signed [rwh_pkg::HUE_W-1:0]           hue_degrees,
  output logic [rwh_pkg::SUM_W-1:0]                  red_total,
  output logic [rwh_pkg::SUM_W-1:0]                  green_total,
  output logic [rwh_pkg::SUM_W-1:0]                  blue_total
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int CW = rwh_pkg::CW;
  localparam int ZW = rwh_pkg::ZW;

  rwh_pkg::back_state_t state, state_next;
  rwh_pkg::sums_t sums;
  logic gray;
  logic signed [CW-1:0] x, y, sx, sy;
  logic signed [ZW-1:0] z, zmag;
  logic [STEP_W-1:0] step;
  logic last_step, slot_free, load_out;
  logic signed [21:0] diff_gb;
  logic signed [22:0] diff_y;
  logic signed [39:0] prod;
  logic [ZW-17:0] tmag, tclamp;
  logic signed [ZW-16:0] tsigned;

  assign slot_free = !out_valid || out_ready;
  assign last_step = (step == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= rwh_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    load_out = 1'b0;
    unique case (state)
      rwh_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          state_next = rwh_pkg::ST_SETUP;
        end
      end
      rwh_pkg::ST_SETUP: state_next = rwh_pkg::ST_CLASSIFY;
      rwh_pkg::ST_CLASSIFY: begin
        if (gray || x == '0 || y == '0) state_next = rwh_pkg::ST_FINISH;
        else state_next = rwh_pkg::ST_ROTATE;
      end
      rwh_pkg::ST_ROTATE: begin
        if (last_step) state_next = rwh_pkg::ST_FINISH;
      end
      rwh_pkg::ST_FINISH: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_next = rwh_pkg::ST_IDLE;
        end
      end
      default: state_next = rwh_pkg::ST_IDLE;
    endcase
  end

  // Setup arithmetic: x = sqrt3*(g-b), y = (2r-g-b) in Q16.
  always_comb begin
    diff_gb = $signed({2'b0, sums.green}) - $signed({2'b0, sums.blue});
    diff_y = $signed({2'b0, sums.red, 1'b0}) - $signed({3'b0, sums.green}) -
             $signed({3'b0, sums.blue});
    prod = diff_gb * rwh_pkg::SQRT3_Q16;
    sx = x >>> step;
    sy = y >>> step;
  end

  // Truncate the angle toward zero and clamp it.
  always_comb begin
    zmag = z[ZW-1] ? -z : z;
    tmag = zmag[ZW-1:16];
    tclamp = (tmag > rwh_pkg::HUE_LIMIT) ? rwh_pkg::HUE_LIMIT : tmag;
    tsigned = z[ZW-1] ? -$signed({1'b0, tclamp}) : $signed({1'b0, tclamp});
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rwh_pkg::ST_IDLE: begin
        if (pop) sums <= head;
      end
      rwh_pkg::ST_SETUP: begin
        x <= CW'(prod);
        y <= {{(CW - 39){diff_y[22]}}, diff_y, 16'b0};
        gray <= (sums.red == sums.green) && (sums.green == sums.blue);
      end
      rwh_pkg::ST_CLASSIFY: begin
        step <= '0;
        if (gray) begin
          z <= '0;
        end else if (x == '0) begin
          z <= y[CW-1] ? -rwh_pkg::ANGLE_90 : rwh_pkg::ANGLE_90;
        end else if (y == '0) begin
          z <= x[CW-1] ? rwh_pkg::ANGLE_180 : '0;
        end else if (x[CW-1]) begin
          // Left half-plane: fold the vector over and start from +/-180.
          x <= -x;
          y <= -y;
          z <= y[CW-1] ? -rwh_pkg::ANGLE_180 : rwh_pkg::ANGLE_180;
        end else begin
          z <= '0;
        end
      end
      rwh_pkg::ST_ROTATE: begin
        step <= step + 1'b1;
        if (!y[CW-1]) begin
          x <= x + sy;
          y <= y - sx;
          z <= z + $signed({4'b0, rwh_pkg::atan_deg(5'(step))});
        end else begin
          x <= x - sy;
          y <= y + sx;
          z <= z - $signed({4'b0, rwh_pkg::atan_deg(5'(step))});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      is_gray <= gray;
      hue_degrees <= tsigned[rwh_pkg::HUE_W-1:0];
      red_total <= sums.red;
      green_total <= sums.green;
      blue_total <= sums.blue;
    end
  end

`ifndef ASSERT_OFF
  a_gray_hue_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_gray |-> hue_degrees == '0)
    else $error("gray result carries a nonzero hue");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue_degrees >= -9'sd180 && hue_degrees <= 9'sd180))
    else $error("hue outside -180..180");

  a_rotate_right_half: assert property (@(posedge clk) disable iff (rst)
    state == rwh_pkg::ST_ROTATE && step == '0 |-> !x[CW-1] && x != '0)
    else $error("rotation started outside the right half-plane");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == rwh_pkg::ST_FINISH)
    else $error("result register loaded outside the finish step");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/rgb_window_hue_core.sv
// Top level of the window hue block: pixel intake, sums queue and hue engine.
`default_nettype none
// The block watches a raster pixel stream and sums the red, green and blue
// components of every pixel whose column and row fall inside a rectangle set by
// four configuration registers (left, top, width, height). Each sum saturates at
// 1048575. On the request that carries frame_last, that pixel is summed first and
// the three totals are handed to the hue engine while the accumulators clear, so
// the next frame starts from zero. The engine reports the totals, a
// gray flag (all three totals equal, hue then 0) and the hue
// atan2(2r-g-b, sqrt3*(g-b)) in whole degrees truncated toward zero, computed by a
// vectoring rotator with 16 fractional bits; it may be one degree off exact
// arithmetic near integer boundaries. Pixels are taken one per clock while in_ready
// is high. The engine works on one frame result at a time, one rotation step a
// cycle, and a two-entry queue holds frame totals ahead of it, so in_ready drops
// only when that queue is full. The result waits in an output register while the
// engine and the intake go on. Configuration writes are always taken and belong
// to idle periods between frames.
module rgb_window_hue_core #(
  parameter int COMPONENT_BITS = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [9:0]                       pixel_x,
  input  wire logic [9:0]                       pixel_y,
  input  wire logic [7:0]                       red_value,
  input  wire logic [7:0]                       green_value,
  input  wire logic [7:0]                       blue_value,
  input  wire logic                             frame_last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  is_gray,
  output logic signed [8:0]                     hue_degrees,
  output logic [19:0]                           red_total,
  output logic [19:0]                           green_total,
  output logic [19:0]                           blue_total,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rwh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [9:0]                       cfg_data
);

  rwh_pkg::q_status_t q_status;
  rwh_pkg::sums_t push_data, head;
  logic push, pop;

  // Intake: window test and accumulation at one pixel per clock while in_ready is high.
  rwh_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .red_value(red_value),
    .green_value(green_value),
    .blue_value(blue_value),
    .frame_last(frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_status(q_status),
    .push(push),
    .push_data(push_data)
  );

  // Frame totals wait here so that the intake stalls on the engine only when the queue is full.
  rwh_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(pop),
    .head(head),
    .status(q_status)
  );

  // Hue engine and result register.
  rwh_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .q_status(q_status),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_gray(is_gray),
    .hue_degrees(hue_degrees),
    .red_total(red_total),
    .green_total(green_total),
    .blue_total(blue_total)
  );

endmodule
`default_nettype wire
